[design/lsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg: shared constants and types of the session cache
// Capacity, field widths, slot layout and request kind codes.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int ENTRIES = 32;                  // 2 .. 256
    localparam int IDX_W   = $clog2(ENTRIES);     // slot index and age rank
    localparam int CNT_W   = $clog2(ENTRIES + 1); // fill count, pass counter

    localparam int HOST_W   = 32;
    localparam int SCHEME_W = 8;
    localparam int PORT_W   = 16;
    localparam int VALUE_W  = 32;

    localparam int S_DATA_W = HOST_W + SCHEME_W + PORT_W + VALUE_W; // 88, whole bytes
    localparam int M_DATA_W = VALUE_W;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic [HOST_W-1:0]   host;
        logic [SCHEME_W-1:0] scheme;
        logic [PORT_W-1:0]   port;
    } key_t;

    typedef struct packed {
        key_t               key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage
`default_nettype wire

[design/lsc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/lru_session_cache.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_session_cache: most-recently-used-first session handle cache
//
// Requests arrive on the s_axis channel: tuser carries the kind (get or
// put), tdata the key (host id, scheme id, port) and, for a put, the session
// handle. Each get returns one result on m_axis: tuser = hit, tdata = the
// stored handle on a hit, zero on a miss. A put returns nothing.
// Slots live in two RAMs with registered read data: one holds key and
// handle, one holds the age rank (0 = most recent). A request runs a scan
// pass over the filled slots (one slot read per cycle), a decide step,
// then a rank update pass over the filled slots that rewrites every rank;
// a get that misses skips the update pass. The length of each pass grows
// with the fill count, set by the single read port of each RAM.
// s_axis_tready is high only between requests.
// Reset empties the cache at once (fill count to zero); no clearing pass.
// A result waits in the output register while the receiver stalls; the next
// request is still taken, and only its own result waits for room.
// ----------------------------------------------------------------------------
module lru_session_cache (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: host_id[31:0], scheme_id[39:32], port[55:40], session_value[87:56]
    input  wire logic [lsc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[0]
    input  wire logic                          s_axis_tuser,
    // result channel
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: found_value[31:0]
    output logic      [lsc_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // tuser: hit[0]
    output logic                               m_axis_tuser
);

    import lsc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_RANK   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               match_reg, match_next;
    logic [IDX_W-1:0]   midx_reg, midx_next;
    logic [IDX_W-1:0]   mrank_reg, mrank_next;
    logic [VALUE_W-1:0] mval_reg, mval_next;
    logic [IDX_W-1:0]   victim_reg, victim_next;
    logic [IDX_W-1:0]   target_reg, target_next;
    logic [CNT_W-1:0]   thr_reg, thr_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [VALUE_W-1:0] out_val_reg, out_val_next;

    // captured request
    logic               kind_reg;
    key_t               key_reg;
    logic [VALUE_W-1:0] val_reg;

    // RAM ports
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_t            slot_rd;
    logic [IDX_W-1:0] rank_rd;
    logic             slot_wr_en;
    logic [IDX_W-1:0] slot_wr_addr;
    slot_t            slot_wr_data;
    logic             rank_wr_en;
    logic [IDX_W-1:0] rank_wr_addr;
    logic [IDX_W-1:0] rank_wr_data;

    logic s_accept;
    logic out_free;
    logic pass_done;

    lsc_ram #(.WIDTH($bits(slot_t)), .DEPTH(ENTRIES)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (slot_rd)
    );

    lsc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_wr_en),
        .wr_addr (rank_wr_addr),
        .wr_data (rank_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rank_rd)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = out_val_reg;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pass_done = (cnt_reg == fill_reg) && !pend_reg;

    // Hold the request fields for the whole scan and update.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg       <= s_axis_tuser;
            key_reg.host   <= s_axis_tdata[HOST_W-1:0];
            key_reg.scheme <= s_axis_tdata[HOST_W+SCHEME_W-1:HOST_W];
            key_reg.port   <= s_axis_tdata[HOST_W+SCHEME_W+PORT_W-1:HOST_W+SCHEME_W];
            val_reg        <= s_axis_tdata[S_DATA_W-1:HOST_W+SCHEME_W+PORT_W];
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = cnt_reg[IDX_W-1:0];
        match_next     = match_reg;
        midx_next      = midx_reg;
        mrank_next     = mrank_reg;
        mval_next      = mval_reg;
        victim_next    = victim_reg;
        target_next    = target_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_val_next   = out_val_reg;

        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        slot_wr_en     = 1'b0;
        slot_wr_addr   = midx_reg;
        slot_wr_data   = '{key: key_reg, value: val_reg};
        rank_wr_en     = 1'b0;
        rank_wr_addr   = pidx_reg;
        rank_wr_data   = '0;

        // drop the result once the receiver takes it
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    match_next = 1'b0;
                end
            end

            ST_SCAN: begin
                // read one filled slot per cycle, compare it the next cycle
                if (cnt_reg < fill_reg) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (slot_rd.key == key_reg) begin
                        match_next = 1'b1;
                        midx_next  = pidx_reg;
                        mrank_next = rank_rd;
                        mval_next  = slot_rd.value;
                    end
                    // ranks form a permutation, so the oldest has the top rank
                    if (rank_rd == IDX_W'(ENTRIES - 1)) begin
                        victim_next = pidx_reg;
                    end
                end
                if (pass_done) begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                cnt_next    = '0;
                target_next = midx_reg;
                thr_next    = CNT_W'(mrank_reg);
                if (kind_reg == KIND_GET) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_hit_next   = match_reg;
                        out_val_next   = match_reg ? mval_reg : '0;
                        state_next     = match_reg ? ST_RANK : ST_IDLE;
                    end
                end else begin
                    slot_wr_en = 1'b1;
                    state_next = ST_RANK;
                    if (!match_reg) begin
                        // new key: every other entry ages by one
                        thr_next = CNT_W'(ENTRIES);
                        if (fill_reg == CNT_W'(ENTRIES)) begin
                            slot_wr_addr = victim_reg;
                            target_next  = victim_reg;
                        end else begin
                            slot_wr_addr = fill_reg[IDX_W-1:0];
                            target_next  = fill_reg[IDX_W-1:0];
                            fill_next    = fill_reg + 1'b1;
                        end
                    end
                end
            end

            ST_RANK: begin
                // read rank, write back the next cycle: zero for the target, else aged if below the threshold
                if (cnt_reg < fill_reg) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    rank_wr_en = 1'b1;
                    if (pidx_reg == target_reg) begin
                        rank_wr_data = '0;
                    end else if (CNT_W'(rank_rd) < thr_reg) begin
                        rank_wr_data = rank_rd + 1'b1;
                    end else begin
                        rank_wr_data = rank_rd;
                    end
                end
                if (pass_done) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg    <= pidx_next;
        midx_reg    <= midx_next;
        mrank_reg   <= mrank_next;
        mval_reg    <= mval_next;
        victim_reg  <= victim_next;
        target_reg  <= target_next;
        thr_reg     <= thr_next;
        out_hit_reg <= out_hit_next;
        out_val_reg <= out_val_next;
    end

endmodule
`default_nettype wire
